FILE: design/mvt_pkg.sv
// shared types and constants for the 4x4 matrix-vector transform
package mvt_pkg;

  localparam int DIM = 4;

  typedef enum logic [1:0] {
    REG_ROW0 = 2'd0,
    REG_ROW1 = 2'd1,
    REG_ROW2 = 2'd2,
    REG_ROW3 = 2'd3
  } reg_idx_t;

  // handshake pair carried between neighboring stages
  typedef struct packed {
    logic valid;
    logic ready;
  } flow_t;

endpackage

FILE: design/mvt_cell.sv
// one column cell: multiplies its vector component into all four row sums
module mvt_cell #(
  parameter int EW  = 16,
  parameter int COL = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mvt_pkg::DIM*EW-1:0]        vec_in,
  input  logic [mvt_pkg::DIM*(2*EW+2)-1:0]  acc_in,
  input  logic [mvt_pkg::DIM*EW-1:0]        coef,
  output mvt_pkg::flow_t                    out_flow_valid,
  input  logic                              out_ready,
  output logic [mvt_pkg::DIM*EW-1:0]        vec_out,
  output logic [mvt_pkg::DIM*(2*EW+2)-1:0]  acc_out
);

  localparam int AW = 2 * EW + 2;

  logic                             valid;
  logic signed [EW-1:0]             xv;
  logic signed [2*EW-1:0]           prod [mvt_pkg::DIM];
  logic [mvt_pkg::DIM*AW-1:0]       acc_next;

  assign xv       = vec_in[COL*EW +: EW];
  assign in_ready = !valid || out_ready;

  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      prod[r] = (2*EW)'(xv) * (2*EW)'($signed(coef[r*EW +: EW]));
      acc_next[r*AW +: AW] = $signed(acc_in[r*AW +: AW]) + AW'(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec_out <= vec_in;
      acc_out <= acc_next;
    end
  end

  assign out_flow_valid.valid = valid;
  assign out_flow_valid.ready = in_ready;

endmodule

FILE: design/mvt_sat.sv
// output stage: scales the row sums back to the element format and clips them
module mvt_sat #(
  parameter int EW = 16,
  parameter int FB = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mvt_pkg::DIM*(2*EW+2)-1:0]  acc_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mvt_pkg::DIM*EW-1:0]        out_data,
  output logic                              out_sat
);

  localparam int AW = 2 * EW + 2;
  localparam logic signed [AW-1:0] HI = {{(AW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [AW-1:0] LO = ~HI;

  logic signed [AW-1:0]        scaled [mvt_pkg::DIM];
  logic [mvt_pkg::DIM*EW-1:0]  data_next;
  logic                        sat_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sat_next = 1'b0;
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      // arithmetic shift rounds toward minus infinity
      scaled[r] = $signed(acc_in[r*AW +: AW]) >>> FB;
      if (scaled[r] > HI) begin
        data_next[r*EW +: EW] = HI[EW-1:0];
        sat_next = 1'b1;
      end else if (scaled[r] < LO) begin
        data_next[r*EW +: EW] = LO[EW-1:0];
        sat_next = 1'b1;
      end else begin
        data_next[r*EW +: EW] = scaled[r][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
      out_sat  <= sat_next;
    end
  end

endmodule

FILE: design/matrix4_vector_transform.sv
// top level: 4x4 matrix times 4-vector, row registers on an apb port
// Takes one vector beat per cycle while the output is not stalled and returns one result
// beat per vector: the vector walks through a row of four column cells, each adding its
// component times one matrix column into four running row sums, and a final register
// shifts, clips and holds the result. Every stage has its own valid bit, so stalls on the
// output side back up only as far as needed and gaps are filled. The matrix rows reset to
// identity and are rewritten through the apb port at byte addresses 0, 8, 16 and 24; the
// saturated flag in m_tuser is set when any component was clipped.
module matrix4_vector_transform #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [4:0]                                paddr,
  input  logic [63:0]                               pwdata,
  output logic [63:0]                               prdata,
  output logic                                      pready,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // in_x, in_y, in_z, in_w from bit 0 up
  input  logic [((mvt_pkg::DIM*ELEMENT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // out_x, out_y, out_z, out_w from bit 0 up
  output logic [((mvt_pkg::DIM*ELEMENT_WIDTH+7)/8)*8-1:0] m_tdata,
  // saturated
  output logic                                      m_tuser
);

  localparam int EW  = ELEMENT_WIDTH;
  localparam int AW  = 2 * EW + 2;
  localparam int VW  = mvt_pkg::DIM * EW;
  localparam int TDW = ((VW + 7) / 8) * 8;
  localparam int RW  = (VW > 64) ? VW : 64;

  function automatic logic [63:0] identity_row(input int r);
    logic [RW-1:0] one_hot;
    one_hot = RW'(1) << (FRACTION_BITS + r * EW);
    return one_hot[63:0];
  endfunction

  localparam logic [63:0] IDENT0 = identity_row(0);
  localparam logic [63:0] IDENT1 = identity_row(1);
  localparam logic [63:0] IDENT2 = identity_row(2);
  localparam logic [63:0] IDENT3 = identity_row(3);

  logic [63:0]        rows [mvt_pkg::DIM];
  logic [RW-1:0]      row_ext [mvt_pkg::DIM];
  logic [VW-1:0]      col_coef [mvt_pkg::DIM];
  logic               cfg_wr;
  mvt_pkg::reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = mvt_pkg::reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= IDENT0;
      rows[1] <= IDENT1;
      rows[2] <= IDENT2;
      rows[3] <= IDENT3;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mvt_pkg::REG_ROW0: rows[0] <= pwdata;
        mvt_pkg::REG_ROW1: rows[1] <= pwdata;
        mvt_pkg::REG_ROW2: rows[2] <= pwdata;
        mvt_pkg::REG_ROW3: rows[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mvt_pkg::REG_ROW0: prdata = rows[0];
      mvt_pkg::REG_ROW1: prdata = rows[1];
      mvt_pkg::REG_ROW2: prdata = rows[2];
      mvt_pkg::REG_ROW3: prdata = rows[3];
      default:           prdata = '0;
    endcase
  end

  // elements past bit 63 of a row read as zero
  always_comb begin
    for (int r = 0; r < mvt_pkg::DIM; r++) begin
      row_ext[r] = RW'(rows[r]);
    end
    for (int c = 0; c < mvt_pkg::DIM; c++) begin
      for (int r = 0; r < mvt_pkg::DIM; r++) begin
        col_coef[c][r*EW +: EW] = row_ext[r][c*EW +: EW];
      end
    end
  end

  // cell chain
  logic [VW-1:0]                 vec_link [mvt_pkg::DIM+1];
  logic [mvt_pkg::DIM*AW-1:0]    acc_link [mvt_pkg::DIM+1];
  logic                          valid_link [mvt_pkg::DIM+1];
  logic                          ready_link [mvt_pkg::DIM+1];
  mvt_pkg::flow_t                cell_flow [mvt_pkg::DIM];
  logic [VW-1:0]                 out_data;

  assign vec_link[0]   = s_tdata[VW-1:0];
  assign acc_link[0]   = '0;
  assign valid_link[0] = s_tvalid;
  assign s_tready      = ready_link[0];

  for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_cell
    mvt_cell #(
      .EW  (EW),
      .COL (c)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .in_valid       (valid_link[c]),
      .in_ready       (ready_link[c]),
      .vec_in         (vec_link[c]),
      .acc_in         (acc_link[c]),
      .coef           (col_coef[c]),
      .out_flow_valid (cell_flow[c]),
      .out_ready      (ready_link[c+1]),
      .vec_out        (vec_link[c+1]),
      .acc_out        (acc_link[c+1])
    );
    assign valid_link[c+1] = cell_flow[c].valid;
  end

  mvt_sat #(
    .EW (EW),
    .FB (FRACTION_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_link[mvt_pkg::DIM]),
    .in_ready  (ready_link[mvt_pkg::DIM]),
    .acc_in    (acc_link[mvt_pkg::DIM]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .out_sat   (m_tuser)
  );

  assign m_tdata = TDW'(out_data);

  localparam logic [EW-1:0] SAT_HI = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_LO = {1'b1, {(EW-1){1'b0}}};

  a_reset_identity: assert property (@(posedge clk)
    rst |=> (rows[0] == IDENT0 && rows[1] == IDENT1 && rows[2] == IDENT2 && rows[3] == IDENT3))
    else $error("matrix rows not identity after reset");

  a_row0_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && cfg_idx == mvt_pkg::REG_ROW0) |=> rows[0] == $past(pwdata))
    else $error("row 0 write lost");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (out_data[0*EW +: EW] == SAT_HI || out_data[0*EW +: EW] == SAT_LO ||
       out_data[1*EW +: EW] == SAT_HI || out_data[1*EW +: EW] == SAT_LO ||
       out_data[2*EW +: EW] == SAT_HI || out_data[2*EW +: EW] == SAT_LO ||
       out_data[3*EW +: EW] == SAT_HI || out_data[3*EW +: EW] == SAT_LO))
    else $error("saturated flag without a clipped component");

  a_chain_ready: assert property (@(posedge clk) disable iff (rst)
    (!cell_flow[0].valid) |-> s_tready)
    else $error("input stalled with first cell empty");

endmodule
